@@ design/elrm_pkg.sv @@
package elrm_pkg;

   // Knob position wraps at a power of two equal to the step range, so the
   // wrap is plain modular arithmetic on POS_W bits.
   localparam int POSITION_STEPS = 32;
   localparam int POS_W          = $clog2(POSITION_STEPS);

   localparam int VALUE_W    = 16;
   localparam int STEP_W     = 5;
   localparam int LED_W      = 4;
   localparam int QUO_W      = 4;
   localparam int DIVIDEND_W = VALUE_W + 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [VALUE_W-1:0] DEFAULT_MAX = 16'd127;
   localparam logic [LED_W-1:0]   LED_FULL    = 4'd11;
   localparam logic [LED_W-1:0]   LED_HALF    = 4'd6;
   localparam logic [7:0]         MSG_B0_BASE = 8'h40;
   localparam logic [7:0]         MSG_B1_BASE = 8'h30;
   localparam logic [7:0]         MSG_B2      = 8'hB0;
   localparam logic [7:0]         MSG_B3      = 8'h20;

   typedef enum logic [1:0] {
      CSR_MIN_VALUE,
      CSR_MAX_VALUE,
      CSR_RING_MODE,
      CSR_CONTROL_INDEX
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_DOT,
      MODE_BOOST_CUT,
      MODE_WRAP,
      MODE_SPREAD
   } ring_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_DIVIDE,
      ST_EMIT_FIRST,
      ST_EMIT_SECOND
   } state_type;

   // LEDs to send for one tick, in send order
   typedef struct packed {
      logic [1:0]       count;
      logic [LED_W-1:0] led_a;
      logic [LED_W-1:0] led_b;
   } plan_type;

   function automatic plan_type ring_plan(ring_mode_type mode, logic [LED_W-1:0] lvl,
                                          logic upper);
      plan_type p;
      p.count = 2'd0;
      p.led_a = lvl;
      p.led_b = lvl;
      unique case (mode)
         MODE_DOT: begin
            p.count = 2'd1;
         end
         MODE_BOOST_CUT: begin
            if (upper) begin
               if (lvl > LED_HALF) begin
                  p.count = 2'd2;
                  p.led_a = lvl - 4'd1;
               end else if (lvl == LED_HALF) begin
                  p.count = 2'd1;
               end
            end else begin
               // below center: one LED above the level, sent first
               if (lvl < 4'd5) begin
                  p.count = 2'd2;
                  p.led_a = lvl + 4'd1;
               end else begin
                  p.count = 2'd1;
               end
            end
         end
         MODE_WRAP: begin
            p.count = 2'd2;
            p.led_a = lvl - 4'd1;
         end
         MODE_SPREAD: begin
            if (upper) begin
               if (lvl > LED_HALF) begin
                  p.count = 2'd2;
                  p.led_a = lvl - 4'd6;
                  p.led_b = lvl - 4'd5;
               end else if (lvl == LED_HALF) begin
                  p.count = 2'd1;
                  p.led_a = 4'd1;
               end
            end else begin
               if (lvl < LED_HALF) begin
                  p.count = 2'd2;
                  p.led_a = 4'd6 - lvl;
                  p.led_b = 4'd7 - lvl;
               end else if (lvl == LED_HALF) begin
                  p.count = 2'd1;
                  p.led_a = 4'd1;
               end
            end
         end
         default: begin
            p.count = 2'd0;
         end
      endcase
      return p;
   endfunction

   function automatic logic [31:0] ring_message(logic [1:0] mode, logic [3:0] index,
                                                logic [LED_W-1:0] led);
      logic [7:0] b0;
      logic [7:0] b1;
      b0 = MSG_B0_BASE | {2'b00, mode, 4'h0} | {4'h0, led};
      b1 = MSG_B1_BASE | {4'h0, index};
      return {b0, b1, MSG_B2, MSG_B3};
   endfunction

endpackage

@@ design/encoder_led_ring_messenger_core.sv @@
// A request passes through the update, scale and divide states before the first result;
// no new request is taken until the last result of the tick has been taken, so a stall
// on the result side holds the flow. The 4-step compare-subtract divider forms the
// LED level.
// Reset: synchronous, active high; knob position and value clear to zero,
// registers return to min 0, max 127, dot mode, control index 0.
module encoder_led_ring_messenger_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_direction,
   input  logic [elrm_pkg::STEP_W-1:0]        req_step,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [4:0]                         rsp_position,
   output logic [elrm_pkg::VALUE_W-1:0]       rsp_knob_value,
   output logic [31:0]                        rsp_ring_message,
   output logic                               rsp_message_valid,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [elrm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import elrm_pkg::*;

   state_type             state_ff, state_in;
   logic [VALUE_W-1:0]    min_ff, max_ff;
   logic [1:0]            mode_ff;
   logic [3:0]            index_ff;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  dir_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  sat_ff, upper_ff;
   plan_type              plan_ff;

   logic [VALUE_W-1:0]    max_eff;
   logic [VALUE_W:0]      floor_sum, up_sum;
   logic [DIVIDEND_W-1:0] scaled;
   logic                  div_start, div_done;
   logic [QUO_W-1:0]      quotient;
   logic [LED_W-1:0]      level;
   logic                  req_take, rsp_take;

   assign max_eff   = (max_ff == '0) ? DEFAULT_MAX : max_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   // value and position update
   assign floor_sum = {1'b0, min_ff} + {{(VALUE_W+1-STEP_W){1'b0}}, step_ff};
   assign up_sum    = {1'b0, value_ff} + {{(VALUE_W+1-STEP_W){1'b0}}, step_ff};

   always_comb begin
      pos_in   = pos_ff;
      value_in = value_ff;
      if (state_ff == ST_UPDATE) begin
         if (dir_ff) begin
            pos_in = pos_ff - POS_W'(step_ff);
            // compare value - step < min without wrap, using one extra bit
            if ({1'b0, value_ff} < floor_sum) begin
               value_in = '0;
            end else begin
               value_in = value_ff - VALUE_W'(step_ff);
            end
         end else begin
            pos_in = pos_ff + POS_W'(step_ff);
            if (up_sum > {1'b0, max_eff}) begin
               value_in = max_eff;
            end else begin
               value_in = up_sum[VALUE_W-1:0];
            end
         end
      end
   end

   // 11 * value
   assign scaled = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
                 + {4'b0000, value_ff};

   elrm_level_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (max_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   // value at or above max saturates the level; divider result is unused then
   always_comb begin
      if (sat_ff) begin
         level = LED_FULL;
      end else if (quotient == '0) begin
         level = 4'd1;
      end else begin
         level = quotient;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_EMIT_FIRST;
         end
         ST_EMIT_FIRST: begin
            if (rsp_take) state_in = (plan_ff.count == 2'd2) ? ST_EMIT_SECOND : ST_IDLE;
         end
         ST_EMIT_SECOND: begin
            if (rsp_take) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = 1'b0;
      div_start         = 1'b0;
      rsp_valid         = 1'b0;
      rsp_last          = 1'b0;
      rsp_message_valid = 1'b0;
      rsp_ring_message  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCALE: begin
            div_start = 1'b1;
         end
         ST_EMIT_FIRST: begin
            rsp_valid         = 1'b1;
            rsp_last          = (plan_ff.count != 2'd2);
            rsp_message_valid = (plan_ff.count != 2'd0);
            if (plan_ff.count != 2'd0) begin
               rsp_ring_message = ring_message(mode_ff, index_ff, plan_ff.led_a);
            end
         end
         ST_EMIT_SECOND: begin
            rsp_valid         = 1'b1;
            rsp_last          = 1'b1;
            rsp_message_valid = 1'b1;
            rsp_ring_message  = ring_message(mode_ff, index_ff, plan_ff.led_b);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_position   = 5'(pos_ff);
   assign rsp_knob_value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff   <= '0;
         max_ff   <= DEFAULT_MAX;
         mode_ff  <= MODE_DOT;
         index_ff <= '0;
         pos_ff   <= '0;
         value_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         value_ff <= value_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_MIN_VALUE:     min_ff   <= csr_wdata[VALUE_W-1:0];
               CSR_MAX_VALUE:     max_ff   <= csr_wdata[VALUE_W-1:0];
               CSR_RING_MODE:     mode_ff  <= csr_wdata[1:0];
               CSR_CONTROL_INDEX: index_ff <= csr_wdata[3:0];
               default:           mode_ff  <= mode_ff;
            endcase
         end
      end
      if (req_take) begin
         dir_ff  <= req_direction;
         step_ff <= req_step;
      end
      if (state_ff == ST_SCALE) begin
         sat_ff   <= (value_ff >= max_eff);
         upper_ff <= ({1'b0, value_ff, 1'b0} >= {2'b00, max_eff});
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         plan_ff <= ring_plan(ring_mode_type'(mode_ff), level, upper_ff);
      end
   end

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request taken while a tick is in progress");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   a_second_needs_two: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_SECOND |-> plan_ff.count == 2'd2)
      else $error("second message without a two-message plan");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_message_valid) |-> (rsp_last && rsp_ring_message == '0))
      else $error("empty result not final");

   a_led_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_valid) |-> rsp_ring_message[27:24] <= LED_FULL)
      else $error("LED index out of range");

endmodule

@@ design/elrm_level_div.sv @@
module elrm_level_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [elrm_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [elrm_pkg::VALUE_W-1:0]       divisor,
   output logic                               done,
   output logic [elrm_pkg::QUO_W-1:0]         quotient
);
   import elrm_pkg::*;

   localparam int BIT_W = $clog2(QUO_W);

   // Restoring division, one quotient bit per cycle, MSB first.
   // Caller guarantees dividend < 2**QUO_W * divisor.
   logic [DIVIDEND_W-1:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0]       div_ff, div_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVIDEND_W-1:0]    shifted;

   assign shifted = {{(DIVIDEND_W-VALUE_W){1'b0}}, div_ff} << bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         div_in  = divisor;
         quo_in  = '0;
         bit_in  = BIT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in = rem_ff - shifted;
            quo_in = quo_ff | (QUO_W'(1) << bit_ff);
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ bench/tb.sv @@
module tb;
   import elrm_pkg::*;

   localparam logic TURN_UP   = 1'b0;
   localparam logic TURN_DOWN = 1'b1;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   PHASE_TICKS    = 50;
   localparam int   RANDOM_PHASES  = 10;

   typedef struct packed {
      logic       direction;
      logic [4:0] step;
   } tick_type;

   typedef struct packed {
      logic [4:0]  position;
      logic [15:0] knob_value;
      logic [31:0] ring_word;
      logic        message_valid;
      logic        last;
   } ring_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_direction = 1'b0;
   logic [4:0]  req_step = 5'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_position;
   logic [15:0] rsp_knob_value;
   logic [31:0] rsp_ring_message;
   logic        rsp_message_valid;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   // predictor state and its copy of the registers
   logic [4:0]    knob_pos = 5'd0;
   int            knob_val = 0;
   logic [15:0]   cfg_min = 16'd0;
   logic [15:0]   cfg_max = 16'd127;
   ring_mode_type cfg_mode = MODE_DOT;
   logic [3:0]    cfg_index = 4'd0;

   tick_type        tick_pending[$];
   ring_result_type ring_expect[$];
   tick_type        tick_next;
   ring_result_type got_result;
   ring_result_type want_result;
   int           ticks_queued = 0;
   int           ticks_taken = 0;
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           req_wait = 0;
   int           rsp_wait = 0;
   bit           req_steady = 1'b0;
   bit           rsp_steady = 1'b0;

   encoder_led_ring_messenger_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_direction    (req_direction),
      .req_step         (req_step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_knob_value   (rsp_knob_value),
      .rsp_ring_message (rsp_ring_message),
      .rsp_message_valid(rsp_message_valid),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 11);
   endfunction

   // Advances knob position and value by one tick, then queues the LED ring
   // results it should produce, a marker with no message when the span is empty.
   task automatic apply_tick(logic dir, logic [4:0] step);
      int mx;
      int lvl;
      int lo;
      int hi;
      int n;
      int led;
      int k;
      int leds[2];
      bit upper;
      bit descending;
      ring_result_type r;
      mx = (cfg_max == 16'd0) ? 127 : int'(cfg_max);
      if (dir == TURN_DOWN) begin
         knob_pos = knob_pos - step;
         if (knob_val - int'(step) < int'(cfg_min))
            knob_val = 0;
         else
            knob_val = knob_val - int'(step);
      end else begin
         knob_pos = knob_pos + step;
         if (knob_val + int'(step) > mx)
            knob_val = mx;
         else
            knob_val = knob_val + int'(step);
      end

      lvl = (11 * knob_val) / mx;
      if (lvl > 11) lvl = 11;
      if (lvl == 0) lvl = 1;
      upper = (2 * knob_val) >= mx;

      lo = 0;
      hi = -1;
      descending = 1'b0;
      case (cfg_mode)
         MODE_DOT: begin
            lo = lvl;
            hi = lvl;
         end
         MODE_BOOST_CUT: begin
            if (upper) begin
               lo = (lvl - 1 < 6) ? 6 : lvl - 1;
               hi = lvl;
            end else begin
               // below center the LED above the level goes out first
               lo = lvl;
               hi = (lvl + 1 >= 6) ? lvl : lvl + 1;
               descending = 1'b1;
            end
         end
         MODE_WRAP: begin
            lo = lvl - 1;
            hi = lvl;
         end
         default: begin
            if (upper) begin
               lo = ((lvl - 1 < 6) ? 6 : lvl - 1) - 5;
               hi = lvl - 5;
            end else begin
               lo = ((11 - lvl < 6) ? 6 : 11 - lvl) - 5;
               hi = 7 - lvl;
            end
         end
      endcase

      n = 0;
      if (descending) begin
         for (led = hi; led >= lo && n < 2; led--) begin
            leds[n] = led;
            n++;
         end
      end else begin
         for (led = lo; led <= hi && n < 2; led++) begin
            leds[n] = led;
            n++;
         end
      end

      r.position   = knob_pos;
      r.knob_value = knob_val[15:0];
      if (n == 0) begin
         // empty LED span: a single marker result with no message
         r.ring_word     = 32'd0;
         r.message_valid = 1'b0;
         r.last          = 1'b1;
         ring_expect.push_back(r);
      end else begin
         for (k = 0; k < n; k++) begin
            r.ring_word = {MSG_B0_BASE | {2'b00, cfg_mode, 4'h0} | {4'h0, 4'(leds[k])},
                           MSG_B1_BASE | {4'h0, cfg_index}, MSG_B2, MSG_B3};
            r.message_valid = 1'b1;
            r.last          = (k == n - 1);
            ring_expect.push_back(r);
         end
      end
   endtask

   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h, got %h", field, want, got);
   endtask

   task automatic queue_tick(logic dir, logic [4:0] step);
      tick_type t;
      t.direction = dir;
      t.step      = step;
      tick_pending.push_back(t);
      ticks_queued++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_VALUE:     cfg_min = data;
         CSR_MAX_VALUE:     cfg_max = data;
         CSR_RING_MODE:     cfg_mode = ring_mode_type'(data[1:0]);
         CSR_CONTROL_INDEX: cfg_index = data[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] min_v, logic [15:0] max_v, ring_mode_type mode,
                             logic [3:0] index);
      csr_write(CSR_MIN_VALUE, min_v);
      csr_write(CSR_MAX_VALUE, max_v);
      csr_write(CSR_RING_MODE, {14'd0, mode});
      csr_write(CSR_CONTROL_INDEX, {12'd0, index});
      @(negedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      while (ticks_taken != ticks_queued || ring_expect.size() != 0) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_tick(req_direction, req_step);
            ticks_taken++;
            if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
            req_wait = draw_wait(req_steady);
         end
         if (req_valid && !req_ready) begin
            // hold the request until taken
         end else if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (tick_pending.size() > 0) begin
            tick_next = tick_pending.pop_front();
            req_direction <= tick_next.direction;
            req_step      <= tick_next.step;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result = {rsp_position, rsp_knob_value, rsp_ring_message,
                          rsp_message_valid, rsp_last};
            if (ring_expect.size() == 0) begin
               note_mismatch("unexpected result", 32'd0, rsp_ring_message);
            end else begin
               want_result = ring_expect.pop_front();
               if (got_result.position !== want_result.position)
                  note_mismatch("position", want_result.position, got_result.position);
               if (got_result.knob_value !== want_result.knob_value)
                  note_mismatch("knob_value", want_result.knob_value, got_result.knob_value);
               if (got_result.ring_word !== want_result.ring_word)
                  note_mismatch("ring_message", want_result.ring_word, got_result.ring_word);
               if (got_result.message_valid !== want_result.message_valid)
                  note_mismatch("message_valid", want_result.message_valid,
                                got_result.message_valid);
               if (got_result.last !== want_result.last)
                  note_mismatch("last", want_result.last, got_result.last);
            end
            if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
            rsp_wait = draw_wait(rsp_steady);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   initial begin
      int p;
      int k;
      logic [15:0] min_pick;
      logic [15:0] max_pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // register defaults: max 127, step extremes
      @(negedge clock);
      queue_tick(TURN_UP, 5'd0);
      for (k = 0; k < 4; k++) queue_tick(TURN_UP, 5'd31);
      queue_tick(TURN_DOWN, 5'd31);
      drain();

      // boost/cut with max 21: value above max, saturated and upper pairs, lower half pair
      set_config(16'd0, 16'd21, MODE_BOOST_CUT, 4'd15);
      queue_tick(TURN_DOWN, 5'd31);
      queue_tick(TURN_UP, 5'd11);
      queue_tick(TURN_UP, 5'd1);
      queue_tick(TURN_UP, 5'd31);
      queue_tick(TURN_DOWN, 5'd4);
      queue_tick(TURN_DOWN, 5'd8);
      drain();

      // spread: lower half, empty span, full scale
      set_config(16'd0, 16'd21, MODE_SPREAD, 4'd5);
      queue_tick(TURN_DOWN, 5'd31);
      queue_tick(TURN_UP, 5'd11);
      queue_tick(TURN_UP, 5'd10);
      drain();

      // wrap with min above the value: level floor and a decrease down to zero
      set_config(16'd40000, 16'd65535, MODE_WRAP, 4'd0);
      queue_tick(TURN_UP, 5'd31);
      queue_tick(TURN_DOWN, 5'd1);
      drain();

      // climb to 200, then drop max to 0 so the value sits above the bound
      set_config(16'd0, 16'd200, MODE_DOT, 4'd15);
      for (k = 0; k < 7; k++) queue_tick(TURN_UP, 5'd31);
      drain();
      set_config(16'd0, 16'd0, MODE_DOT, 4'd15);
      queue_tick(TURN_DOWN, 5'd0);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       min_pick = 16'd0;
            1, 2:    min_pick = 16'($urandom_range(0, 40));
            default: min_pick = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 7))
            0:       max_pick = 16'd0;
            1:       max_pick = 16'd1;
            2, 3, 4: max_pick = 16'($urandom_range(2, 40));
            5, 6:    max_pick = 16'($urandom_range(41, 400));
            default: max_pick = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         endcase
         set_config(min_pick, max_pick, ring_mode_type'($urandom_range(0, 3)),
                    4'($urandom_range(0, 15)));
         for (k = 0; k < PHASE_TICKS; k++)
            queue_tick(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && ring_expect.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/elrm_pkg.sv
design/elrm_level_div.sv
design/encoder_led_ring_messenger_core.sv
bench/tb.sv
